[hw/rtl/crrl_pkg.sv]
// shared codes and constants of the record ring log
package crrl_pkg;

  typedef enum logic [2:0] {
    ActWrite   = 3'd0,
    ActReadPop = 3'd1,
    ActReadPos = 3'd2,
    ActDelete  = 3'd3,
    ActFlush   = 3'd4,
    ActFormat  = 3'd5
  } action_e;

  typedef enum logic [2:0] {
    StatOk       = 3'd0,
    StatEmpty    = 3'd1,
    StatFull     = 3'd2,
    StatChecksum = 3'd3,
    StatTag      = 3'd4
  } status_e;

  localparam int CfgIdxW = 1;
  localparam logic [CfgIdxW-1:0] CfgSlotLimit  = 1'b0;
  localparam logic [CfgIdxW-1:0] CfgWrittenTag = 1'b1;

  localparam logic [8:0] SlotLimitReset  = 9'd256;
  localparam logic [7:0] WrittenTagReset = 8'd165;
  localparam logic [7:0] ErasedByte      = 8'hFF;

endpackage

[hw/rtl/crrl_ram.sv]
// generic single write port ram with registered read
module crrl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[hw/rtl/checksummed_record_ring_log.sv]
// top level of the checksummed record ring log: sequencer around the record store
// write byte: each byte is staged while idle; the last byte stores the framed record, busy high
// read: a checksum walk over the whole record, then the payload bytes are read again
// and come out one payload byte per cycle
// delete and format: each record is rewritten in turn with an erased payload
// all timing set by the byte-wide ports of the record store; results cannot stall
// after reset a clearing pass erases the store, busy high
module checksummed_record_ring_log import crrl_pkg::*; #(
  parameter int SLOTS        = 256,
  parameter int RECORD_BYTES = 32
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // command channel
  input  logic                         start,
  output logic                         busy,
  input  logic [2:0]                   action_i,
  input  logic [7:0]                   data_in_i,
  input  logic                         data_last_i,
  input  logic [7:0]                   slot_position_i,
  input  logic signed [9:0]            delete_count_i,
  // result channel
  output logic                         res_valid_o,
  output logic [7:0]                   data_out_o,
  output logic                         last_out_o,
  output logic [2:0]                   status_o,
  output logic [$clog2(SLOTS+1)-1:0]   records_held_o,
  // configuration channel
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [CfgIdxW-1:0]           cfg_index_i,
  input  logic [8:0]                   cfg_data_i
);

  localparam int PAYLOAD = RECORD_BYTES - 2;
  localparam int DEPTH   = SLOTS * RECORD_BYTES;
  localparam int SW      = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CW      = $clog2(SLOTS + 1);
  localparam int AW      = $clog2(DEPTH);
  localparam int BW      = $clog2(RECORD_BYTES + 1);
  localparam int PW      = $clog2(PAYLOAD);
  localparam int FW      = $clog2(PAYLOAD + 1);
  localparam int RW      = (CW > 9) ? CW : 9;

  // sequencer states
  localparam logic [2:0] StClear  = 3'd0;
  localparam logic [2:0] StIdle   = 3'd1;
  localparam logic [2:0] StWrite  = 3'd2;
  localparam logic [2:0] StDelChk = 3'd3;
  localparam logic [2:0] StSum    = 3'd4;
  localparam logic [2:0] StEmit   = 3'd5;

  // base address of the record in a slot
  function automatic logic [AW-1:0] base_of(input logic [SW-1:0] slot);
    return AW'(32'(slot) * RECORD_BYTES);
  endfunction

  // next slot, wrapping at the effective limit
  function automatic logic [SW-1:0] advance(input logic [SW-1:0] p, input logic [CW-1:0] lim);
    logic [CW-1:0] n;
    n = CW'(p) + 1'b1;
    return (n >= lim) ? '0 : SW'(n);
  endfunction

  // control state
  logic [2:0]    state_q, state_d;
  logic [AW-1:0] clr_q, clr_d;
  logic [BW-1:0] cnt_q, cnt_d;
  logic [FW-1:0] fill_q, fill_d;
  logic [SW-1:0] head_q, head_d;
  logic [SW-1:0] tail_q, tail_d;
  logic [CW-1:0] count_q, count_d;
  logic [8:0]    limit_q;
  logic [7:0]    tag_q;
  logic          res_valid_q, res_valid_d;

  // working registers of the current command
  logic [AW-1:0] base_q, base_d;
  logic [7:0]    sum_q, sum_d;
  logic [7:0]    chk_q, chk_d;
  status_e       rstat_q, rstat_d;
  logic [FW-1:0] wfill_q, wfill_d;
  logic [RW-1:0] rem_q, rem_d;
  logic [SW-1:0] fmt_q, fmt_d;
  action_e       op_q, op_d;

  // result payload registers
  logic [7:0]    data_q, data_d;
  logic          last_q, last_d;
  status_e       status_q, status_d;
  logic [CW-1:0] held_q;

  // memory ports
  logic          st_we, st_re;
  logic [AW-1:0] st_waddr, st_raddr;
  logic [7:0]    st_wdata, st_rdata;
  logic          sg_we, sg_re;
  logic [PW-1:0] sg_waddr, sg_raddr;
  logic [7:0]    sg_wdata, sg_rdata;

  logic          accept;
  logic [CW-1:0] eff_lim;
  logic [FW-1:0] new_fill;
  logic [BW-1:0] widx;
  logic [7:0]    wbyte;
  logic [SW-1:0] pos_mod [256];

  // record store, one byte per entry
  crrl_ram #(
    .WIDTH (8),
    .DEPTH (DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (st_we),
    .waddr_i (st_waddr),
    .wdata_i (st_wdata),
    .re_i    (st_re),
    .raddr_i (st_raddr),
    .rdata_o (st_rdata)
  );

  // stage buffer for the record being assembled
  crrl_ram #(
    .WIDTH (8),
    .DEPTH (PAYLOAD)
  ) u_stage (
    .clk_i   (clk_i),
    .we_i    (sg_we),
    .waddr_i (sg_waddr),
    .wdata_i (sg_wdata),
    .re_i    (sg_re),
    .raddr_i (sg_raddr),
    .rdata_o (sg_rdata)
  );

  // constant table: read position folded into the slot range
  for (genvar g = 0; g < 256; g++) begin : g_pos_mod
    assign pos_mod[g] = SW'(g % SLOTS);
  end

  assign accept      = start && !busy;
  assign busy        = (state_q != StIdle);
  assign cfg_ready_o = 1'b1;

  // zero acts as one slot, anything above SLOTS acts as SLOTS
  always_comb begin
    if (limit_q == '0) begin
      eff_lim = CW'(1);
    end else if (32'(limit_q) > SLOTS) begin
      eff_lim = CW'(SLOTS);
    end else begin
      eff_lim = CW'(limit_q);
    end
  end

  // stage fill after taking this byte; extra bytes are dropped
  assign new_fill = (fill_q < FW'(PAYLOAD)) ? fill_q + 1'b1 : fill_q;

  // byte written to the store during a record write: staged payload,
  // erased padding, inverted sum, then the tag
  assign widx = cnt_q - 1'b1;
  always_comb begin
    if (widx < BW'(PAYLOAD)) begin
      wbyte = (widx < BW'(wfill_q)) ? sg_rdata : ErasedByte;
    end else if (widx == BW'(PAYLOAD)) begin
      wbyte = ~sum_q;
    end else begin
      wbyte = tag_q;
    end
  end

  always_comb begin
    state_d     = state_q;
    clr_d       = clr_q;
    cnt_d       = cnt_q;
    fill_d      = fill_q;
    head_d      = head_q;
    tail_d      = tail_q;
    count_d     = count_q;
    base_d      = base_q;
    sum_d       = sum_q;
    chk_d       = chk_q;
    rstat_d     = rstat_q;
    wfill_d     = wfill_q;
    rem_d       = rem_q;
    fmt_d       = fmt_q;
    op_d        = op_q;
    res_valid_d = 1'b0;
    data_d      = '0;
    last_d      = 1'b1;
    status_d    = StatOk;

    st_we    = 1'b0;
    st_waddr = base_q + AW'(widx);
    st_wdata = wbyte;
    st_re    = 1'b0;
    st_raddr = base_q + AW'(cnt_q);
    sg_we    = 1'b0;
    sg_waddr = fill_q[PW-1:0];
    sg_wdata = data_in_i;
    sg_re    = 1'b0;
    sg_raddr = cnt_q[PW-1:0];

    unique case (state_q)
      // erase the whole store after reset
      StClear: begin
        st_we    = 1'b1;
        st_waddr = clr_q;
        st_wdata = ErasedByte;
        clr_d    = clr_q + 1'b1;
        if (clr_q == AW'(DEPTH - 1)) begin
          state_d = StIdle;
        end
      end

      StIdle: begin
        if (accept) begin
          unique case (action_i)
            ActWrite: begin
              if (fill_q < FW'(PAYLOAD)) begin
                sg_we  = 1'b1;
                fill_d = new_fill;
              end
              if (data_last_i) begin
                fill_d = '0;
                if (count_q >= eff_lim) begin
                  res_valid_d = 1'b1;
                  status_d    = StatFull;
                end else begin
                  wfill_d = new_fill;
                  base_d  = base_of(head_q);
                  cnt_d   = '0;
                  sum_d   = '0;
                  op_d    = ActWrite;
                  state_d = StWrite;
                end
              end
            end
            ActReadPop: begin
              if (count_q == '0) begin
                res_valid_d = 1'b1;
                status_d    = StatEmpty;
              end else begin
                // pop up front so the results carry the new count
                count_d = count_q - 1'b1;
                tail_d  = advance(tail_q, eff_lim);
                base_d  = base_of(tail_q);
                cnt_d   = '0;
                sum_d   = '0;
                state_d = StSum;
              end
            end
            ActReadPos: begin
              base_d  = base_of(pos_mod[slot_position_i]);
              cnt_d   = '0;
              sum_d   = '0;
              state_d = StSum;
            end
            ActDelete: begin
              if (count_q == '0) begin
                res_valid_d = 1'b1;
                status_d    = StatEmpty;
              end else begin
                // negative count means everything stored
                rem_d   = delete_count_i[9] ? RW'(count_q) : RW'(delete_count_i[8:0]);
                state_d = StDelChk;
              end
            end
            ActFlush: begin
              head_d      = '0;
              tail_d      = '0;
              count_d     = '0;
              res_valid_d = 1'b1;
            end
            ActFormat: begin
              head_d  = '0;
              tail_d  = '0;
              count_d = '0;
              fmt_d   = '0;
              base_d  = '0;
              wfill_d = '0;
              cnt_d   = '0;
              sum_d   = '0;
              op_d    = ActFormat;
              state_d = StWrite;
            end
            default: begin
              res_valid_d = 1'b1;
            end
          endcase
        end
      end

      // write one framed record, each stage byte is read in the cycle before its store write
      StWrite: begin
        sg_re = (cnt_q < BW'(PAYLOAD));
        if (cnt_q != '0) begin
          st_we = 1'b1;
          if (widx < BW'(PAYLOAD)) begin
            sum_d = sum_q + wbyte;
          end
        end
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == BW'(RECORD_BYTES)) begin
          cnt_d = '0;
          sum_d = '0;
          if (op_q == ActDelete) begin
            count_d = count_q - 1'b1;
            tail_d  = advance(tail_q, eff_lim);
            rem_d   = rem_q - 1'b1;
            state_d = StDelChk;
          end else if (op_q == ActFormat) begin
            if (fmt_q == SW'(SLOTS - 1)) begin
              res_valid_d = 1'b1;
              state_d     = StIdle;
            end else begin
              fmt_d  = fmt_q + 1'b1;
              base_d = base_of(fmt_q + 1'b1);
            end
          end else begin
            count_d     = count_q + 1'b1;
            head_d      = advance(head_q, eff_lim);
            res_valid_d = 1'b1;
            state_d     = StIdle;
          end
        end
      end

      // blank the next tail record or finish
      StDelChk: begin
        if (rem_q == '0 || count_q == '0) begin
          res_valid_d = 1'b1;
          state_d     = StIdle;
        end else begin
          base_d  = base_of(tail_q);
          wfill_d = '0;
          cnt_d   = '0;
          sum_d   = '0;
          op_d    = ActDelete;
          state_d = StWrite;
        end
      end

      // first pass over the record: payload sum, stored checksum, tag
      StSum: begin
        st_re = (cnt_q < BW'(RECORD_BYTES));
        if (cnt_q != '0) begin
          if (widx < BW'(PAYLOAD)) begin
            sum_d = sum_q + st_rdata;
          end else if (widx == BW'(PAYLOAD)) begin
            chk_d = st_rdata;
          end
        end
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == BW'(RECORD_BYTES)) begin
          if (chk_q != ~sum_q) begin
            rstat_d = StatChecksum;
          end else if (st_rdata != tag_q) begin
            rstat_d = StatTag;
          end else begin
            rstat_d = StatOk;
          end
          cnt_d   = '0;
          state_d = StEmit;
        end
      end

      // second pass: one payload byte per cycle
      StEmit: begin
        st_re = 1'b1;
        if (cnt_q != '0) begin
          res_valid_d = 1'b1;
          data_d      = st_rdata;
          last_d      = (cnt_q == BW'(PAYLOAD));
          status_d    = rstat_q;
        end
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == BW'(PAYLOAD)) begin
          cnt_d   = '0;
          state_d = StIdle;
        end
      end

      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StClear;
      clr_q       <= '0;
      cnt_q       <= '0;
      fill_q      <= '0;
      head_q      <= '0;
      tail_q      <= '0;
      count_q     <= '0;
      res_valid_q <= 1'b0;
      limit_q     <= SlotLimitReset;
      tag_q       <= WrittenTagReset;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      cnt_q       <= cnt_d;
      fill_q      <= fill_d;
      head_q      <= head_d;
      tail_q      <= tail_d;
      count_q     <= count_d;
      res_valid_q <= res_valid_d;
      // configuration transfer
      if (cfg_valid_i && cfg_ready_o) begin
        unique case (cfg_index_i)
          CfgSlotLimit:  limit_q <= cfg_data_i;
          CfgWrittenTag: tag_q   <= cfg_data_i[7:0];
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    base_q   <= base_d;
    sum_q    <= sum_d;
    chk_q    <= chk_d;
    rstat_q  <= rstat_d;
    wfill_q  <= wfill_d;
    rem_q    <= rem_d;
    fmt_q    <= fmt_d;
    op_q     <= op_d;
    data_q   <= data_d;
    last_q   <= last_d;
    status_q <= status_d;
    if (res_valid_d) begin
      held_q <= count_d;
    end
  end

  assign res_valid_o    = res_valid_q;
  assign data_out_o     = data_q;
  assign last_out_o     = last_q;
  assign status_o       = status_q;
  assign records_held_o = held_q;

  // ring count never passes the number of slots
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(SLOTS))
    else $error("record count above slot count");

  // stage fill stays within one payload
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= FW'(PAYLOAD))
    else $error("stage fill overflow");

  // payload bytes of a read come back to back up to the final one
  a_read_burst: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && !last_out_o) |=> res_valid_o)
    else $error("gap inside a read burst");

  // a result is only produced while working or on the cycle after an accept
  a_result_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_q |-> ($past(state_q) != StIdle) || $past(accept))
    else $error("result without a command");

endmodule
